### hdl/sdtq_pkg.sv
`default_nettype none

package sdtq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TICK_DONE = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] handle;
    logic [31:0] deadline;
    logic [31:0] current_time;
  } cmd_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] expired_handle;
    logic        last;
  } res_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_TICK
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic        rm_head;
    logic [31:0] deadline;
    logic [15:0] handle;
  } cell_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [15:0] handle;
  } cell_entry_t;

  typedef struct packed {
    logic shift;
    logic after;
  } cell_flag_t;

endpackage

`default_nettype wire

### hdl/sdtq_cell.sv
`default_nettype none

module sdtq_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  sdtq_pkg::cell_cmd_t   cmd,
  input  sdtq_pkg::cell_entry_t prev_entry,
  input  sdtq_pkg::cell_flag_t  prev_flag,
  input  sdtq_pkg::cell_entry_t next_entry,
  output sdtq_pkg::cell_entry_t entry,
  output sdtq_pkg::cell_flag_t  flag
);
  import sdtq_pkg::*;

  cell_entry_t entry_next;
  logic        match;
  logic        take_new;

  always_comb begin
    match      = entry.valid && (cmd.rm_head || (entry.handle == cmd.handle));
    flag.shift = entry.valid && (entry.deadline > cmd.deadline);
    flag.after = prev_flag.after || match;
    take_new   = !prev_flag.shift && (flag.shift || (!entry.valid && prev_entry.valid));
    entry_next = entry;
    case (cmd.op)
      CELL_INSERT: begin
        if (prev_flag.shift) begin
          entry_next = prev_entry;
        end else if (take_new) begin
          entry_next = '{valid: 1'b1, deadline: cmd.deadline, handle: cmd.handle};
        end
      end
      CELL_REMOVE: begin
        if (flag.after) begin
          entry_next = next_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.deadline <= entry_next.deadline;
    entry.handle   <= entry_next.handle;
  end

endmodule

`default_nettype wire

### hdl/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue.
// Commands arrive on the cmd channel and results leave on the res channel,
// both valid/ready; a beat moves when valid and ready are high together.
// Each command is add, adjust, delete or tick. Timers live in a row of DEPTH
// cells kept in ascending deadline order; an insert or a removal moves every
// affected cell by one place in the same cycle.
// An add or a delete gives a single result; an adjust does its removal,
// then its insertion, or stops after the removal when its handle is
// missing. A tick gives one result per expired timer, oldest first, then
// the finishing beat marked last.
// One command is in work at a time; cmd_ready is high while the queue is
// idle, so a new command may be taken while the last result still waits.
// Results sit in an output register; while the receiver stalls, the queue
// holds its work and the register holds its beat unchanged.
// Reset empties the queue and drops any pending result.
`default_nettype none

module sorted_deadline_timer_queue #(
  parameter int unsigned DEPTH = sdtq_pkg::DEPTH_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  sdtq_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  wire                 res_ready,
  output sdtq_pkg::res_item_t res
);
  import sdtq_pkg::*;

  state_t      state;
  state_t      state_next;
  cmd_item_t   cur;
  cell_cmd_t   cell_cmd;
  cell_entry_t entries [DEPTH];
  cell_flag_t  flags [DEPTH];
  logic        slot_free;
  logic        emit;
  res_item_t   emit_item;
  logic        found;
  logic        full;
  logic        head_due;
  logic        order_ok;

  localparam cell_entry_t HEAD_ENTRY = '{valid: 1'b1, deadline: '0, handle: '0};
  localparam cell_flag_t  HEAD_FLAG  = '{shift: 1'b0, after: 1'b0};
  localparam cell_entry_t TAIL_ENTRY = '{valid: 1'b0, deadline: '0, handle: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_entry_t prev_entry;
    cell_flag_t  prev_flag;
    cell_entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_entry = HEAD_ENTRY;
      assign prev_flag  = HEAD_FLAG;
    end else begin : g_mid
      assign prev_entry = entries[i-1];
      assign prev_flag  = flags[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = TAIL_ENTRY;
    end else begin : g_body
      assign next_entry = entries[i+1];
    end
    sdtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd),
      .prev_entry (prev_entry),
      .prev_flag  (prev_flag),
      .next_entry (next_entry),
      .entry      (entries[i]),
      .flag       (flags[i])
    );
  end

  assign slot_free = !res_valid || res_ready;
  assign found     = flags[DEPTH-1].after;
  assign full      = entries[DEPTH-1].valid;
  assign head_due  = entries[0].valid && (entries[0].deadline <= cur.current_time);
  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
  end

  always_comb begin
    state_next = state;
    cell_cmd   = '{op: CELL_HOLD, rm_head: 1'b0, deadline: cur.deadline,
                   handle: cur.handle};
    emit       = 1'b0;
    emit_item  = '{status: ST_OK, expired_handle: '0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.opcode)
            OP_ADD:                  state_next = S_INSERT;
            OP_ADJUST, OP_DELETE:    state_next = S_REMOVE;
            OP_TICK:                 state_next = S_TICK;
            default:                 state_next = S_IDLE;
          endcase
        end
      end
      S_INSERT: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (full) begin
            emit_item.status = ST_FULL;
          end else begin
            cell_cmd.op = CELL_INSERT;
          end
        end
      end
      S_REMOVE: begin
        if (slot_free) begin
          if (!found) begin
            emit             = 1'b1;
            emit_item.status = ST_NOT_FOUND;
            state_next       = S_IDLE;
          end else begin
            cell_cmd.op = CELL_REMOVE;
            if (cur.opcode == OP_ADJUST) begin
              state_next = S_INSERT;
            end else begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      S_TICK: begin
        cell_cmd.rm_head = 1'b1;
        if (slot_free) begin
          emit = 1'b1;
          if (head_due) begin
            cell_cmd.op = CELL_REMOVE;
            emit_item   = '{status: ST_EXPIRED, expired_handle: entries[0].handle,
                            last: 1'b0};
          end else begin
            emit_item.status = ST_TICK_DONE;
            state_next       = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_item;
    end
  end

  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (entries[i+1].valid && !entries[i].valid) begin
        order_ok = 1'b0;
      end
      if (entries[i+1].valid && (entries[i+1].deadline < entries[i].deadline)) begin
        order_ok = 1'b0;
      end
    end
  end

  a_order: assert property (@(posedge clk) disable iff (rst) order_ok)
    else $error("Timer cells are out of order or have a gap.");

  a_tick_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_TICK_DONE) |-> res.last)
    else $error("Tick finishing beat is not marked last.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> (state != S_IDLE))
    else $error("Accepted command left the queue idle.");

endmodule

`default_nettype wire
